>>> src/brtes_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brtes_pkg
// Shared constants and types of the button/timer event scanner.
// ----------------------------------------------------------------------------
package brtes_pkg;

    localparam int BUTTONS     = 8;
    localparam int TIMERS      = 4;
    localparam int MAX_RESULTS = 12;

    localparam int TIMER_IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
    localparam int RES_W    = $clog2(MAX_RESULTS + 1);

    localparam logic [1:0] KIND_TICK       = 2'd0;
    localparam logic [1:0] KIND_SET_PERIOD = 2'd1;
    localparam logic [1:0] KIND_CLR_TIMER  = 2'd2;

    localparam logic [2:0] EV_PRESS   = 3'd0;
    localparam logic [2:0] EV_RELEASE = 3'd1;
    localparam logic [2:0] EV_REPEAT  = 3'd2;
    localparam logic [2:0] EV_TIMER   = 3'd3;
    localparam logic [2:0] EV_NONE    = 3'd4;

    typedef struct packed {
        logic       is_timer;
        logic       was_down;
        logic       now_down;
        logic [7:0] count;
        logic [7:0] target;
        logic       space_ok;
    } t_step_req;

    typedef struct packed {
        logic       offer;
        logic       accepted;
        logic [2:0] ev_kind;
        logic [7:0] count;
        logic       down;
    } t_step_rsp;

endpackage
`default_nettype wire

>>> src/brtes_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brtes_step
// Shared per-element unit: edge detect, count increment and compare.
// ----------------------------------------------------------------------------
module brtes_step (
    input  var brtes_pkg::t_step_req i_req,
    output var brtes_pkg::t_step_rsp o_rsp
);
    import brtes_pkg::*;

    logic [7:0] inc;
    logic       hit;

    assign inc = i_req.count + 8'd1;
    assign hit = (inc == i_req.target);

    always_comb begin
        o_rsp.offer   = 1'b0;
        o_rsp.ev_kind = EV_NONE;
        o_rsp.count   = i_req.count;
        o_rsp.down    = i_req.was_down;
        if (i_req.is_timer) begin
            if (i_req.target != 8'd0) begin
                if (hit) begin
                    o_rsp.offer   = 1'b1;
                    o_rsp.ev_kind = EV_TIMER;
                    o_rsp.count   = i_req.space_ok ? 8'd0 : i_req.count;
                end else begin
                    o_rsp.count = inc;
                end
            end
        end else if (!i_req.was_down && i_req.now_down) begin
            o_rsp.offer   = 1'b1;
            o_rsp.ev_kind = EV_PRESS;
            o_rsp.count   = 8'd0;
            o_rsp.down    = i_req.space_ok;
        end else if (i_req.was_down && !i_req.now_down) begin
            o_rsp.offer   = 1'b1;
            o_rsp.ev_kind = EV_RELEASE;
            o_rsp.down    = !i_req.space_ok;
        end else if (i_req.was_down && i_req.target != 8'd0) begin
            if (hit) begin
                o_rsp.offer   = 1'b1;
                o_rsp.ev_kind = EV_REPEAT;
                o_rsp.count   = i_req.space_ok ? 8'd0 : i_req.count;
            end else begin
                o_rsp.count = inc;
            end
        end
        o_rsp.accepted = o_rsp.offer && i_req.space_ok;
    end

endmodule
`default_nettype wire

>>> src/button_repeat_timer_event_scanner.sv
`default_nettype none
// ----------------------------------------------------------------------------
// button_repeat_timer_event_scanner
// Scans buttons and timers per tick and emits press, release, repeat and
// timer events, limited by the free queue space carried on the tick.
// ----------------------------------------------------------------------------
// channel   direction  handshake                 payload
// input     in         i_valid / o_stall         kind, pressed_mask, queue_space,
//                                                 timer_index, period_ticks
// result    out        o_valid / i_stall         event_kind, event_index,
//                                                 buttons_down, last
// config    in         i_cfg_valid / o_cfg_ready repeat_period
//
// A tick is accepted, then every button and then every timer is scanned, one element
// per cycle through the shared step unit, then the results are shown in order, as
// the result side takes them.
// Other items are accepted, then give a single result.
// Input is stalled from acceptance until the last result is taken.
// Reset is synchronous, active low, and clears all counts and compares.
// ----------------------------------------------------------------------------
module button_repeat_timer_event_scanner (
    input  var logic       i_clk,
    input  var logic       i_rst_n,
    input  var logic       i_valid,
    output var logic       o_stall,
    input  var logic [1:0] i_kind,
    input  var logic [7:0] i_pressed_mask,
    input  var logic [3:0] i_queue_space,
    input  var logic [1:0] i_timer_index,
    input  var logic [7:0] i_period_ticks,
    output var logic       o_valid,
    input  var logic       i_stall,
    output var logic [2:0] o_event_kind,
    output var logic [2:0] o_event_index,
    output var logic [7:0] o_buttons_down,
    output var logic       o_last,
    input  var logic       i_cfg_valid,
    output var logic       o_cfg_ready,
    input  var logic [7:0] i_cfg_data
);
    import brtes_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_BTN  = 4'b0010,
        S_TMR  = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    localparam logic [2:0]       BTN_LAST = 3'(BUTTONS - 1);
    localparam logic [2:0]       TMR_LAST = 3'(TIMERS - 1);
    localparam logic [3:0]       TIMERS_W = 4'(TIMERS);
    localparam logic [RES_W-1:0] MAX_RES  = RES_W'(MAX_RESULTS);

    t_state           r_state, n_state;
    logic [7:0]       r_period;
    logic [7:0]       r_down;
    logic [7:0]       r_mask;
    logic [7:0]       r_rep   [8];
    logic [7:0]       r_tcnt  [TIMERS];
    logic [7:0]       r_tcmp  [TIMERS];
    logic [2:0]       r_idx;
    logic [RES_W-1:0] r_space;
    logic [RES_W-1:0] r_emitted;
    logic [RES_W-1:0] r_out;
    logic [2:0]       r_pkind [MAX_RESULTS];
    logic [2:0]       r_pidx  [MAX_RESULTS];

    t_step_req         req;
    t_step_rsp         rsp;
    logic              in_acc, out_acc, cfg_acc;
    logic [TIMER_IW-1:0] tix;
    logic [TIMER_IW-1:0] cix;
    logic              cix_ok;
    logic [RES_W-1:0]  qs_ext;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;
    assign cfg_acc = i_cfg_valid && o_cfg_ready;
    assign tix     = r_idx[TIMER_IW-1:0];
    assign cix     = TIMER_IW'(i_timer_index);
    assign cix_ok  = ({2'b00, i_timer_index} < TIMERS_W);
    assign qs_ext  = RES_W'(i_queue_space);

    always_comb begin
        req.is_timer = r_state == S_TMR;
        req.was_down = r_down[r_idx];
        req.now_down = r_mask[r_idx];
        req.space_ok = r_emitted < r_space;
        if (r_state == S_TMR) begin
            req.count  = r_tcnt[tix];
            req.target = r_tcmp[tix];
        end else begin
            req.count  = r_rep[r_idx];
            req.target = r_period;
        end
    end

    brtes_step u_step (
        .i_req (req),
        .o_rsp (rsp)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_kind == KIND_TICK) ? S_BTN : S_EMIT;
                end
            end
            S_BTN: begin
                if (r_idx == BTN_LAST) begin
                    n_state = S_TMR;
                end
            end
            S_TMR: begin
                if (r_idx == TMR_LAST) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_acc && o_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_period  <= 8'd0;
            r_down    <= 8'd0;
            r_idx     <= 3'd0;
            r_space   <= '0;
            r_emitted <= '0;
            r_out     <= '0;
            for (int i = 0; i < 8; i++) begin
                r_rep[i] <= 8'd0;
            end
            for (int i = 0; i < TIMERS; i++) begin
                r_tcnt[i] <= 8'd0;
                r_tcmp[i] <= 8'd0;
            end
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_idx     <= 3'd0;
                        r_out     <= '0;
                        r_emitted <= '0;
                        r_mask    <= i_pressed_mask;
                        r_space   <= (qs_ext > MAX_RES) ? MAX_RES : qs_ext;
                        if (i_kind == KIND_SET_PERIOD && cix_ok) begin
                            r_tcmp[cix] <= i_period_ticks;
                            r_tcnt[cix] <= 8'd0;
                        end else if (i_kind == KIND_CLR_TIMER && cix_ok) begin
                            r_tcnt[cix] <= 8'd0;
                        end
                    end
                end
                S_BTN: begin
                    r_rep[r_idx]  <= rsp.count;
                    r_down[r_idx] <= rsp.down;
                    if (rsp.accepted) begin
                        r_emitted <= r_emitted + 1'b1;
                    end
                    r_idx <= (r_idx == BTN_LAST) ? 3'd0 : r_idx + 3'd1;
                end
                S_TMR: begin
                    r_tcnt[tix] <= rsp.count;
                    if (rsp.accepted) begin
                        r_emitted <= r_emitted + 1'b1;
                    end
                    r_idx <= r_idx + 3'd1;
                end
                S_EMIT: begin
                    if (out_acc && !o_last) begin
                        r_out <= r_out + 1'b1;
                    end
                end
                default: ;
            endcase
            if (cfg_acc) begin
                r_period <= i_cfg_data;
                for (int i = 0; i < 8; i++) begin
                    r_rep[i] <= 8'd0;
                end
            end
        end
    end

    // capture accepted events
    always_ff @(posedge i_clk) begin
        if ((r_state == S_BTN || r_state == S_TMR) && rsp.accepted) begin
            r_pkind[r_emitted] <= rsp.ev_kind;
            r_pidx[r_emitted]  <= (r_state == S_TMR) ? {{(3-TIMER_IW){1'b0}}, tix} : r_idx;
        end
    end

    assign o_stall        = r_state != S_IDLE;
    assign o_cfg_ready    = r_state == S_IDLE;
    assign o_valid        = r_state == S_EMIT;
    assign o_buttons_down = r_down;
    assign o_event_kind   = (r_emitted == '0) ? EV_NONE : r_pkind[r_out];
    assign o_event_index  = (r_emitted == '0) ? 3'd0 : r_pidx[r_out];
    assign o_last         = (r_emitted == '0) || (r_out + 1'b1 == r_emitted);

`ifndef ASSERT_OFF
    a_space_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emitted <= r_space)
        else $error("event count exceeds queue space");

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_stall |-> !o_valid)
        else $error("input ready while a result is shown");

    a_none_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_event_kind == EV_NONE) |-> o_last)
        else $error("no-event result not marked last");

    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_last) |=> (!o_valid && !o_stall))
        else $error("block not idle after last result");
`endif

endmodule
`default_nettype wire

>>> tb/brtes_event_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brtes_event_checker
// Watches the item, result and register channels of the event scanner. It
// keeps its own copy of the button, repeat and timer state, works out the
// events of every accepted item and compares each result in order.
// ----------------------------------------------------------------------------
module brtes_event_checker (
    input  var logic       i_clk,
    input  var logic       i_rst_n,
    input  var logic       i_in_valid,
    input  var logic       i_in_stall,
    input  var logic [1:0] i_kind,
    input  var logic [7:0] i_pressed_mask,
    input  var logic [3:0] i_queue_space,
    input  var logic [1:0] i_timer_index,
    input  var logic [7:0] i_period_ticks,
    input  var logic       i_out_valid,
    input  var logic       i_out_stall,
    input  var logic [2:0] i_event_kind,
    input  var logic [2:0] i_event_index,
    input  var logic [7:0] i_buttons_down,
    input  var logic       i_last,
    input  var logic       i_cfg_valid,
    input  var logic       i_cfg_ready,
    input  var logic [7:0] i_cfg_data,
    output var int         o_fail_count,
    output var int         o_pending,
    output var int         o_items_seen,
    output var int         o_events_seen
);
    import brtes_pkg::*;

    typedef struct packed {
        logic [2:0] kind;
        logic [2:0] index;
        logic [7:0] down;
        logic       last;
    } t_event;

    t_event     expected_events [$];
    logic [2:0] new_kind [$];
    logic [2:0] new_index [$];
    int         room;

    logic [7:0] repeat_period;
    logic [7:0] down_state;
    logic [7:0] repeat_count [BUTTONS];
    logic [7:0] tmr_cnt [TIMERS];
    logic [7:0] tmr_cmp [TIMERS];

    int fail_count  = 0;
    int items_seen  = 0;
    int events_seen = 0;

    assign o_fail_count  = fail_count;
    assign o_items_seen  = items_seen;
    assign o_events_seen = events_seen;

    task automatic report_mismatch(input string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        fail_count++;
    endtask

    function automatic bit offer_event(input logic [2:0] kind, input int index);
        if (new_kind.size() >= room) begin
            return 1'b0;
        end
        new_kind.push_back(kind);
        new_index.push_back(3'(index));
        return 1'b1;
    endfunction

    task automatic scan_item(input logic [1:0] kind, input logic [7:0] mask,
                             input logic [3:0] space, input logic [1:0] tidx,
                             input logic [7:0] per);
        t_event ev;
        new_kind.delete();
        new_index.delete();
        room = (int'(space) > MAX_RESULTS) ? MAX_RESULTS : int'(space);
        case (kind)
            KIND_TICK: begin
                for (int b = 0; b < BUTTONS; b++) begin
                    if (!down_state[b] && mask[b]) begin
                        repeat_count[b] = '0;
                        if (offer_event(EV_PRESS, b)) begin
                            down_state[b] = 1'b1;
                        end
                    end else if (down_state[b] && !mask[b]) begin
                        if (offer_event(EV_RELEASE, b)) begin
                            down_state[b] = 1'b0;
                        end
                    end else if (down_state[b] && mask[b] && repeat_period != 0) begin
                        repeat_count[b] = repeat_count[b] + 8'd1;
                        if (repeat_count[b] == repeat_period) begin
                            if (offer_event(EV_REPEAT, b)) begin
                                repeat_count[b] = '0;
                            end else begin
                                repeat_count[b] = repeat_count[b] - 8'd1;
                            end
                        end
                    end
                end
                for (int t = 0; t < TIMERS; t++) begin
                    if (tmr_cmp[t] != 0) begin
                        tmr_cnt[t] = tmr_cnt[t] + 8'd1;
                        if (tmr_cnt[t] == tmr_cmp[t]) begin
                            if (offer_event(EV_TIMER, t)) begin
                                tmr_cnt[t] = '0;
                            end else begin
                                tmr_cnt[t] = tmr_cnt[t] - 8'd1;
                            end
                        end
                    end
                end
            end
            KIND_SET_PERIOD: begin
                if (int'(tidx) < TIMERS) begin
                    tmr_cmp[tidx] = per;
                    tmr_cnt[tidx] = '0;
                end
            end
            KIND_CLR_TIMER: begin
                if (int'(tidx) < TIMERS) begin
                    tmr_cnt[tidx] = '0;
                end
            end
            default: begin
            end
        endcase
        if (new_kind.size() == 0) begin
            new_kind.push_back(EV_NONE);
            new_index.push_back('0);
        end
        for (int k = 0; k < new_kind.size(); k++) begin
            ev.kind  = new_kind[k];
            ev.index = new_index[k];
            ev.down  = down_state;
            ev.last  = (k == new_kind.size() - 1);
            expected_events.push_back(ev);
        end
    endtask

    task automatic check_event(input t_event got);
        t_event want;
        if (expected_events.size() == 0) begin
            report_mismatch($sformatf("event kind %0d index %0d with nothing expected",
                                      got.kind, got.index));
        end else begin
            want = expected_events.pop_front();
            if (got.kind !== want.kind) begin
                report_mismatch($sformatf("event_kind %0d, want %0d", got.kind, want.kind));
            end
            if (got.index !== want.index) begin
                report_mismatch($sformatf("event_index %0d, want %0d",
                                          got.index, want.index));
            end
            if (got.down !== want.down) begin
                report_mismatch($sformatf("buttons_down %02h, want %02h",
                                          got.down, want.down));
            end
            if (got.last !== want.last) begin
                report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            repeat_period = '0;
            down_state    = '0;
            for (int b = 0; b < BUTTONS; b++) begin
                repeat_count[b] = '0;
            end
            for (int t = 0; t < TIMERS; t++) begin
                tmr_cnt[t] = '0;
                tmr_cmp[t] = '0;
            end
            expected_events.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                repeat_period = i_cfg_data;
                for (int b = 0; b < BUTTONS; b++) begin
                    repeat_count[b] = '0;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                scan_item(i_kind, i_pressed_mask, i_queue_space, i_timer_index,
                          i_period_ticks);
                items_seen++;
            end
            if (i_out_valid && !i_out_stall) begin
                check_event({i_event_kind, i_event_index, i_buttons_down, i_last});
                events_seen++;
            end
        end
        o_pending <= expected_events.size();
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the event scanner with a directed set of ticks and timer commands,
// then random phases under several repeat periods, with random gaps on the
// item side and random stalls on the result side. Gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import brtes_pkg::*;

    localparam int         HALF_PERIOD    = 5;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         SETTLE_CYCLES  = 20;
    localparam int         PHASE_ITEMS    = 25;
    localparam int         NUM_PHASES     = 6;
    localparam logic [1:0] KIND_UNUSED    = 2'd3;

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_valid        = 1'b0;
    logic [1:0] i_kind         = KIND_TICK;
    logic [7:0] i_pressed_mask = '0;
    logic [3:0] i_queue_space  = '0;
    logic [1:0] i_timer_index  = '0;
    logic [7:0] i_period_ticks = '0;
    logic       i_stall        = 1'b0;
    logic       i_cfg_valid    = 1'b0;
    logic [7:0] i_cfg_data     = '0;

    logic       o_stall;
    logic       o_valid;
    logic [2:0] o_event_kind;
    logic [2:0] o_event_index;
    logic [7:0] o_buttons_down;
    logic       o_last;
    logic       o_cfg_ready;

    int fail_count;
    int pending;
    int items_seen;
    int events_seen;

    bit          calm        = 1'b0;
    logic [7:0]  held_mask   = '0;
    int          stall_left  = 0;
    int unsigned stall_pick;
    int          idle_cycles = 0;
    int          cfg_writes  = 0;
    logic [7:0]  phase_periods [NUM_PHASES] = '{8'd1, 8'd0, 8'd255, 8'd3, 8'd5, 8'd2};

    always #HALF_PERIOD i_clk = ~i_clk;

    button_repeat_timer_event_scanner uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_kind         (i_kind),
        .i_pressed_mask (i_pressed_mask),
        .i_queue_space  (i_queue_space),
        .i_timer_index  (i_timer_index),
        .i_period_ticks (i_period_ticks),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_event_kind   (o_event_kind),
        .o_event_index  (o_event_index),
        .o_buttons_down (o_buttons_down),
        .o_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    brtes_event_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_kind         (i_kind),
        .i_pressed_mask (i_pressed_mask),
        .i_queue_space  (i_queue_space),
        .i_timer_index  (i_timer_index),
        .i_period_ticks (i_period_ticks),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_event_kind   (o_event_kind),
        .i_event_index  (o_event_index),
        .i_buttons_down (o_buttons_down),
        .i_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_items_seen   (items_seen),
        .o_events_seen  (events_seen)
    );

    // hold stall for random stretches: mostly short, a few long
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (calm) begin
            i_stall <= 1'b0;
        end else begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 60) begin
                i_stall    <= 1'b0;
                stall_left <= $urandom_range(0, 4);
            end else if (stall_pick < 92) begin
                i_stall    <= 1'b1;
                stall_left <= $urandom_range(0, 2);
            end else begin
                i_stall    <= 1'b1;
                stall_left <= $urandom_range(10, 40);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: %0d cycles without a handshake", idle_cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int pick_gap();
        int unsigned roll;
        if (calm) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
            return 0;
        end
        if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic send_item(input logic [1:0] kind, input logic [7:0] mask,
                             input logic [3:0] space, input logic [1:0] tidx,
                             input logic [7:0] per);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_kind         <= kind;
        i_pressed_mask <= mask;
        i_queue_space  <= space;
        i_timer_index  <= tidx;
        i_period_ticks <= per;
        do @(posedge i_clk); while (o_stall !== 1'b0);
    endtask

    task automatic write_repeat_period(input logic [7:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_random_item();
        int unsigned roll;
        logic [3:0]  space;
        logic [7:0]  per;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            space = 4'($urandom_range(6, 12));
        end else if (roll < 85) begin
            space = 4'($urandom_range(0, 5));
        end else begin
            space = 4'($urandom_range(13, 15));
        end
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
            per = 8'($urandom_range(1, 6));
        end else if (roll < 65) begin
            per = 8'd0;
        end else if (roll < 75) begin
            per = 8'd255;
        end else begin
            per = 8'($urandom);
        end
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
            send_item(KIND_SET_PERIOD, 8'($urandom), space, 2'($urandom), per);
        end else if (roll < 14) begin
            send_item(KIND_CLR_TIMER, 8'($urandom), space, 2'($urandom), per);
        end else if (roll < 18) begin
            send_item(KIND_UNUSED, 8'($urandom), space, 2'($urandom), per);
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
                held_mask = 8'($urandom);
            end else if (roll < 85) begin
                held_mask ^= 8'(1 << $urandom_range(0, 7));
                if ($urandom_range(0, 1) == 1) begin
                    held_mask ^= 8'(1 << $urandom_range(0, 7));
                end
            end
            send_item(KIND_TICK, held_mask, space, 2'($urandom), per);
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_repeat_period(8'd2);

        send_item(KIND_SET_PERIOD, 8'h00, 4'd0,  2'd0, 8'd1);
        send_item(KIND_SET_PERIOD, 8'hFF, 4'd15, 2'd3, 8'd255);
        send_item(KIND_SET_PERIOD, 8'h00, 4'd12, 2'd1, 8'd0);
        send_item(KIND_TICK,       8'hFF, 4'd15, 2'd0, 8'd0);
        send_item(KIND_TICK,       8'hFF, 4'd12, 2'd0, 8'd0);
        send_item(KIND_TICK,       8'hFF, 4'd3,  2'd0, 8'd0);
        send_item(KIND_TICK,       8'hFF, 4'd12, 2'd0, 8'd0);
        send_item(KIND_TICK,       8'h00, 4'd0,  2'd0, 8'd0);
        send_item(KIND_TICK,       8'h00, 4'd4,  2'd0, 8'd0);
        send_item(KIND_TICK,       8'h00, 4'd12, 2'd0, 8'd0);
        send_item(KIND_TICK,       8'h55, 4'd2,  2'd0, 8'd0);
        send_item(KIND_TICK,       8'hAA, 4'd12, 2'd0, 8'd0);
        send_item(KIND_CLR_TIMER,  8'hFF, 4'd15, 2'd0, 8'hFF);
        send_item(KIND_UNUSED,     8'hA5, 4'd9,  2'd2, 8'h5A);
        send_item(KIND_SET_PERIOD, 8'h00, 4'd12, 2'd2, 8'd3);
        send_item(KIND_SET_PERIOD, 8'h00, 4'd12, 2'd1, 8'd2);
        send_item(KIND_TICK,       8'h0F, 4'd1,  2'd0, 8'd0);
        send_item(KIND_TICK,       8'hF0, 4'd13, 2'd0, 8'd0);
        send_item(KIND_TICK,       8'h0F, 4'd14, 2'd0, 8'd0);
        send_item(KIND_TICK,       8'h00, 4'd12, 2'd0, 8'd0);
        send_item(KIND_TICK,       8'h80, 4'd12, 2'd0, 8'd0);
        send_item(KIND_TICK,       8'h80, 4'd12, 2'd0, 8'd0);
        send_item(KIND_SET_PERIOD, 8'h00, 4'd12, 2'd0, 8'd0);

        phase_periods[4] = 8'($urandom_range(4, 9));
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            calm <= (p == 3);
            write_repeat_period(phase_periods[p]);
            repeat (PHASE_ITEMS) send_random_item();
        end
        wait_drained();

        $display("covered %0d items and %0d events under %0d repeat-period settings",
                 items_seen, events_seen, cfg_writes);
        $display("press, release, repeat and timer events with refusals and stalls");
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
